>>> hw/rtl/sobel_pkg.sv
// Shared types, constants and helpers for the Sobel edge magnitude block.
package sobel_pkg;

    localparam int MAX_COLS  = 1024;
    localparam int MAX_ROWS  = 1024;
    localparam int MIN_DIM   = 3;
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int DIM_W     = 11;
    localparam int PIX_W     = 8;
    localparam int EDGE_W    = 11;
    localparam int LINE_W    = 2 * PIX_W;
    localparam int CFG_IDX_W = 2;

    typedef logic [DIM_W-1:0] dim_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             flush;
    } in_word_t;

    typedef struct packed {
        logic [EDGE_W-1:0] edge_value;
        logic              last;
    } out_word_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COLS  = 2'd0,
        REG_ROWS  = 2'd1,
        REG_LIMIT = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic             valid;
        logic             pix_ok;
        logic             emit;
        logic             zero;
        logic             last;
        logic [COL_W-1:0] addr;
        logic [PIX_W-1:0] pixel;
    } stage_t;

    typedef struct packed {
        logic              en;
        logic [COL_W-1:0]  addr;
        logic [LINE_W-1:0] data;
    } wb_t;

    function automatic dim_t clamp_dim(input dim_t v, input dim_t hi);
        dim_t r;
        if (v < dim_t'(MIN_DIM))
        begin
            r = dim_t'(MIN_DIM);
        end
        else if (v > hi)
        begin
            r = hi;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/sobel_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sobel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/sobel_ctrl.sv
// Configuration registers, raster counters, line store clearing and input stage.
module sobel_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  sobel_pkg::in_word_t              in_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sobel_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sobel_pkg::DIM_W-1:0]      cfg_data,
    input  logic                             b_move,
    input  sobel_pkg::wb_t                   wb,
    output sobel_pkg::stage_t                stage,
    output logic [sobel_pkg::EDGE_W-1:0]     edge_limit,
    output logic                             ram_wr_en,
    output logic [sobel_pkg::COL_W-1:0]      ram_wr_addr,
    output logic [sobel_pkg::LINE_W-1:0]     ram_wr_data,
    output logic                             ram_rd_en,
    output logic [sobel_pkg::COL_W-1:0]      ram_rd_addr
);

    sobel_pkg::dim_t cols_reg;
    sobel_pkg::dim_t rows_reg;
    logic [sobel_pkg::EDGE_W-1:0] limit_reg;

    logic [sobel_pkg::COL_W-1:0] in_col_reg, in_col_next;
    logic [sobel_pkg::ROW_W-1:0] in_row_reg, in_row_next;
    logic [sobel_pkg::COL_W-1:0] out_col_reg, out_col_next;
    logic [sobel_pkg::ROW_W-1:0] out_row_reg, out_row_next;
    sobel_pkg::dim_t             lag_reg, lag_next;
    logic [sobel_pkg::COL_W:0]   clear_reg, clear_next;
    sobel_pkg::stage_t           stage_reg, stage_next;

    sobel_pkg::dim_t cols, rows, cols_m1, rows_m1;
    logic            clear_done;
    logic            accept;
    logic            lag_full;
    logic            emit;
    logic            border;
    logic            fin;
    logic            row_end;
    logic            col_end;
    logic [sobel_pkg::COL_W-1:0] col_addr;

    assign cfg_ready  = 1'b1;
    assign edge_limit = limit_reg;
    assign stage      = stage_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg  <= sobel_pkg::dim_t'(640);
            rows_reg  <= sobel_pkg::dim_t'(480);
            limit_reg <= sobel_pkg::EDGE_W'(255);
        end
        else if (cfg_valid)
        begin
            unique case (sobel_pkg::reg_index_t'(cfg_index))
                sobel_pkg::REG_COLS:  cols_reg  <= cfg_data;
                sobel_pkg::REG_ROWS:  rows_reg  <= cfg_data;
                sobel_pkg::REG_LIMIT: limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cols    = sobel_pkg::clamp_dim(cols_reg, sobel_pkg::dim_t'(sobel_pkg::MAX_COLS));
        rows    = sobel_pkg::clamp_dim(rows_reg, sobel_pkg::dim_t'(sobel_pkg::MAX_ROWS));
        cols_m1 = cols - sobel_pkg::dim_t'(1);
        rows_m1 = rows - sobel_pkg::dim_t'(1);

        clear_done = clear_reg[sobel_pkg::COL_W];
        in_ready   = clear_done && (!stage_reg.valid || b_move);
        accept     = in_valid && in_ready;

        lag_full = lag_reg >= (cols + sobel_pkg::dim_t'(1));
        emit     = in_data.flush ? (lag_reg != '0) : lag_full;

        col_addr = (sobel_pkg::dim_t'(in_col_reg) < cols) ? in_col_reg
                                                           : cols_m1[sobel_pkg::COL_W-1:0];

        row_end = sobel_pkg::dim_t'(out_row_reg) >= rows_m1;
        col_end = sobel_pkg::dim_t'(out_col_reg) >= cols_m1;
        border  = (out_row_reg == '0) || (out_col_reg == '0) || row_end || col_end;
        fin     = row_end && col_end;

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        lag_next     = lag_reg;

        if (accept)
        begin
            if (!in_data.flush)
            begin
                if (sobel_pkg::dim_t'(in_col_reg) + sobel_pkg::dim_t'(1) >= cols)
                begin
                    in_col_next = '0;
                    if (sobel_pkg::dim_t'(in_row_reg) + sobel_pkg::dim_t'(1) >= rows)
                    begin
                        in_row_next = '0;
                    end
                    else
                    begin
                        in_row_next = in_row_reg + sobel_pkg::ROW_W'(1);
                    end
                end
                else
                begin
                    in_col_next = in_col_reg + sobel_pkg::COL_W'(1);
                end
                if (!lag_full)
                begin
                    lag_next = lag_reg + sobel_pkg::dim_t'(1);
                end
            end
            else if (emit)
            begin
                lag_next = lag_reg - sobel_pkg::dim_t'(1);
            end

            if (emit)
            begin
                if (sobel_pkg::dim_t'(out_col_reg) + sobel_pkg::dim_t'(1) >= cols)
                begin
                    out_col_next = '0;
                    if (sobel_pkg::dim_t'(out_row_reg) + sobel_pkg::dim_t'(1) >= rows)
                    begin
                        out_row_next = '0;
                    end
                    else
                    begin
                        out_row_next = out_row_reg + sobel_pkg::ROW_W'(1);
                    end
                end
                else
                begin
                    out_col_next = out_col_reg + sobel_pkg::COL_W'(1);
                end
            end
        end

        stage_next = stage_reg;
        if (accept)
        begin
            stage_next.valid  = 1'b1;
            stage_next.pix_ok = !in_data.flush;
            stage_next.emit   = emit;
            stage_next.zero   = in_data.flush || border;
            stage_next.last   = fin;
            stage_next.addr   = col_addr;
            stage_next.pixel  = in_data.pixel;
        end
        else if (b_move)
        begin
            stage_next.valid = 1'b0;
        end

        clear_next = clear_done ? clear_reg : clear_reg + (sobel_pkg::COL_W + 1)'(1);

        ram_rd_en   = accept;
        ram_rd_addr = col_addr;
        if (!clear_done)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clear_reg[sobel_pkg::COL_W-1:0];
            ram_wr_data = '0;
        end
        else
        begin
            ram_wr_en   = wb.en;
            ram_wr_addr = wb.addr;
            ram_wr_data = wb.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            lag_reg     <= '0;
            clear_reg   <= '0;
            stage_reg   <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            lag_reg     <= lag_next;
            clear_reg   <= clear_next;
            stage_reg   <= stage_next;
        end
    end

endmodule

>>> hw/rtl/sobel_datapath.sv
// 3x3 window, Sobel magnitude, clamp, line store write-back and output register.
module sobel_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sobel_pkg::stage_t                 stage,
    input  logic [sobel_pkg::LINE_W-1:0]      rd_data,
    input  logic [sobel_pkg::EDGE_W-1:0]      edge_limit,
    input  logic                              out_ready,
    output logic                              out_valid,
    output sobel_pkg::out_word_t              out_data,
    output logic                              b_move,
    output sobel_pkg::wb_t                    wb
);

    localparam int SUM_W = sobel_pkg::PIX_W + 2;

    logic [sobel_pkg::PIX_W-1:0] win_reg [3][3];
    logic [sobel_pkg::PIX_W-1:0] nw [3][3];

    logic                 out_valid_reg, out_valid_next;
    sobel_pkg::out_word_t out_data_reg, out_data_next;

    logic                          out_free;
    logic                          load_out;
    logic [SUM_W-1:0]              gx_pos, gx_neg, gy_pos, gy_neg;
    logic [SUM_W-1:0]              gx_abs, gy_abs;
    logic [sobel_pkg::EDGE_W-1:0]  mag;
    logic [sobel_pkg::EDGE_W-1:0]  clamped;

    function automatic logic [SUM_W-1:0] abs_diff(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            nw[k][0] = win_reg[k][1];
            nw[k][1] = win_reg[k][2];
        end
        nw[0][2] = rd_data[sobel_pkg::LINE_W-1:sobel_pkg::PIX_W];
        nw[1][2] = rd_data[sobel_pkg::PIX_W-1:0];
        nw[2][2] = stage.pixel;

        gx_pos = SUM_W'(nw[0][2]) + {1'b0, nw[1][2], 1'b0} + SUM_W'(nw[2][2]);
        gx_neg = SUM_W'(nw[0][0]) + {1'b0, nw[1][0], 1'b0} + SUM_W'(nw[2][0]);
        gy_pos = SUM_W'(nw[2][0]) + {1'b0, nw[2][1], 1'b0} + SUM_W'(nw[2][2]);
        gy_neg = SUM_W'(nw[0][0]) + {1'b0, nw[0][1], 1'b0} + SUM_W'(nw[0][2]);
        gx_abs = abs_diff(gx_pos, gx_neg);
        gy_abs = abs_diff(gy_pos, gy_neg);
        mag    = sobel_pkg::EDGE_W'(gx_abs) + sobel_pkg::EDGE_W'(gy_abs);
        clamped = (mag > edge_limit) ? edge_limit : mag;

        out_free = !out_valid_reg || out_ready;
        b_move   = stage.valid && (!stage.emit || out_free);
        load_out = stage.valid && stage.emit && out_free;

        out_valid_next = out_free ? load_out : out_valid_reg;
        out_data_next  = out_data_reg;
        if (load_out)
        begin
            out_data_next.edge_value = stage.zero ? '0 : clamped;
            out_data_next.last       = stage.last;
        end

        wb.en   = b_move && stage.pix_ok;
        wb.addr = stage.addr;
        wb.data = {rd_data[sobel_pkg::PIX_W-1:0], stage.pixel};
    end

    always_ff @(posedge clk)
    begin
        if (b_move && stage.pix_ok)
        begin
            win_reg <= nw;
        end
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> hw/rtl/sobel_edge_magnitude.sv
// Top level of the Sobel edge magnitude block over a raster pixel stream.
//
// Input channel (in_valid/in_ready/in_data) takes one word per pixel in raster
// order, or a flush word that carries no pixel and pushes out one pending result.
// Output channel (out_valid/out_ready/out_data) gives min(|gx|+|gy|, edge_limit),
// zero on the frame border, with last set on the frame's final result.
// A result belongs to the pixel one row and one column earlier: the first
// cols_in_use+1 pixels give none, and trailing flush words drain the rest.
// Configuration port (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
// write it only while the block is idle.
// Throughput is one word per clock while in_ready is high. A result's input word is
// registered in the input stage, with the line store read data, and then in the output
// register that drives out_valid; the write-back is taken from the input stage.
// After reset the line store is cleared, one entry per cycle, over all 1024 entries;
// in_ready stays low during that pass.
// When the receiver stalls, the held result stays in the output register; one more
// word that carries a result can still enter the input stage before in_ready drops,
// and words that give none keep flowing.
module sobel_edge_magnitude (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  sobel_pkg::in_word_t             in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output sobel_pkg::out_word_t            out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sobel_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sobel_pkg::DIM_W-1:0]     cfg_data
);

    sobel_pkg::stage_t                stage;
    sobel_pkg::wb_t                   wb;
    logic                             b_move;
    logic [sobel_pkg::EDGE_W-1:0]     edge_limit;
    logic                             ram_wr_en;
    logic [sobel_pkg::COL_W-1:0]      ram_wr_addr;
    logic [sobel_pkg::LINE_W-1:0]     ram_wr_data;
    logic                             ram_rd_en;
    logic [sobel_pkg::COL_W-1:0]      ram_rd_addr;
    logic [sobel_pkg::LINE_W-1:0]     ram_rd_data;

    sobel_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .b_move      (b_move),
        .wb          (wb),
        .stage       (stage),
        .edge_limit  (edge_limit),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr)
    );

    sobel_ram #(
        .WIDTH (sobel_pkg::LINE_W),
        .DEPTH (sobel_pkg::MAX_COLS)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    sobel_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .stage      (stage),
        .rd_data    (ram_rd_data),
        .edge_limit (edge_limit),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .out_data   (out_data),
        .b_move     (b_move),
        .wb         (wb)
    );

endmodule
